// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent check that also runs during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/jetp_pkg.sv -----
// Shared types, constants and the colour table for the Julia escape-time block.
// No dependencies; imported by every module of the block.
`default_nettype none

package jetp_pkg;

  localparam int unsigned ITER_LIMIT = 300;
  localparam int unsigned COORD_BITS = 12;

  localparam int unsigned PIX_W      = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned ITER_W     = $clog2(ITER_LIMIT + 1);
  localparam int unsigned ITER_OUT_W = 9;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned ITER_OUT_MAX = (ITER_LIMIT > 511) ? 511 : ITER_LIMIT;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned ITER_LSB  = 3 * COLOR_W;

  localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd512;

  // Q4.28 fixed point
  localparam int unsigned FX_W   = 32;
  localparam int unsigned FRAC   = 28;
  localparam int unsigned PROD_W = 2 * FX_W;
  localparam int unsigned SQ_W   = PROD_W - FRAC;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam logic [SUM_W-1:0] FOUR = SUM_W'(64'd1 << (FRAC + 2));

  localparam int unsigned SPAN_W = 30;
  localparam logic [SPAN_W-1:0] SPAN_Y = 30'd483183821;
  localparam logic [SPAN_W-1:0] SPAN_X = 30'd858993459;
  localparam logic signed [FX_W-1:0] OFF_Y = 32'sd241591910;
  localparam logic signed [FX_W-1:0] OFF_X = 32'sd429496730;
  localparam logic signed [FX_W-1:0] C_RE  = -32'sd212064010;
  localparam logic signed [FX_W-1:0] C_IM  = 32'sd40265318;

  // restoring divider: one quotient bit per cycle over the whole dividend
  localparam int unsigned DVD_W     = SPAN_W + PIX_W;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic                   err;
    logic signed [FX_W-1:0] re;
    logic signed [FX_W-1:0] im;
  } seed_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

  // ---- colour table, evaluated at elaboration only ----
  localparam int unsigned BIG_W = 256;
  typedef logic [BIG_W-1:0] big_t;

  localparam int unsigned RED_SCALE   = 500;
  localparam int unsigned GREEN_SCALE = 255;
  localparam logic [63:0] ROM_DEN = 64'(ITER_LIMIT) * 64'(ITER_LIMIT) * 64'(ITER_LIMIT);

  function automatic big_t big_pow(input big_t base, input int unsigned e);
    big_t acc;
    int unsigned i;
    acc = big_t'(1);
    for (i = 0; i < e; i++) acc = acc * base;
    return acc;
  endfunction

  // largest k in [0,kmax] with k^ek * ITER_LIMIT^em <= kmax^ek * n^em
  function automatic int unsigned root_floor(input int unsigned n, input int unsigned kmax,
                                             input int unsigned ek, input int unsigned em);
    big_t rhs;
    big_t lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rhs = big_pow(big_t'(kmax), ek) * big_pow(big_t'(n), em);
    lo = 0;
    hi = kmax;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = big_pow(big_t'(mid), ek) * big_pow(big_t'(ITER_LIMIT), em);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic color_t color_entry(input int unsigned n);
    color_t      c;
    int unsigned kr;
    int unsigned kg;
    logic [63:0] num;
    logic [63:0] cb;
    if (n == 0) begin
      c.red   = 8'd200;
      c.green = 8'd100;
      c.blue  = 8'd100;
    end else begin
      kr  = root_floor(n, RED_SCALE, 5, 8);     // 500 * b^1.6
      kg  = root_floor(n, GREEN_SCALE, 10, 3);  // 255 * b^0.3
      num = 64'd255 * 64'(n) * 64'(n) * 64'(n);
      cb  = (num + ROM_DEN - 64'd1) / ROM_DEN;  // ceil(255 * b^3)
      c.red   = COLOR_W'(32'd0 - kr);
      c.green = COLOR_W'(32'd0 - kg);
      c.blue  = COLOR_W'(64'd255 - cb);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jetp_front.sv -----
// Front end: accepts pixel requests, checks them against the image size and
// maps them to a complex start point with a shared bit-serial divider. Uses jetp_pkg.
`default_nettype none

module jetp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  jetp_pkg::cfg_t                   cfg,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [jetp_pkg::S_TDATA_W-1:0]   s_tdata,   // pixel_x, pixel_y
  output logic                             push_valid,
  input  logic                             push_ready,
  output jetp_pkg::seed_t                  push_data
);
  import jetp_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV_RE,
    F_DIV_IM,
    F_PUSH
  } front_state_t;

  front_state_t           state;
  logic [PIX_W-1:0]       pix_x;
  logic                   err;
  logic [DIM_W-1:0]       divisor;
  logic [DIM_W-1:0]       rem;
  logic [DVD_W-1:0]       dvd;
  logic [DIV_CNT_W-1:0]   cnt;
  logic signed [FX_W-1:0] re0;
  logic signed [FX_W-1:0] im0;

  logic [PIX_W-1:0] in_x;
  logic [PIX_W-1:0] in_y;
  logic             in_bad;
  logic [DIM_W:0]   trial;
  logic             fits;
  logic [DIM_W-1:0] rem_step;
  logic [DVD_W-1:0] dvd_step;
  logic [SPAN_W-1:0] quot;
  logic             last;

  assign in_x   = s_tdata[PIX_W-1:0] & COORD_MASK;
  assign in_y   = s_tdata[2*PIX_W-1:PIX_W] & COORD_MASK;
  assign in_bad = ({1'b0, in_x} >= cfg.width) || ({1'b0, in_y} >= cfg.height);

  assign trial    = {rem, dvd[DVD_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_step = fits ? DIM_W'(trial - {1'b0, divisor}) : DIM_W'(trial);
  assign dvd_step = {dvd[DVD_W-2:0], fits};
  assign quot     = dvd_step[SPAN_W-1:0];
  assign last     = cnt == DIV_CNT_W'(DVD_W - 1);

  assign s_tready   = state == F_IDLE;
  assign push_valid = state == F_PUSH;
  assign push_data  = '{err: err, re: re0, im: im0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            pix_x   <= in_x;
            err     <= in_bad;
            re0     <= '0;
            im0     <= '0;
            rem     <= '0;
            cnt     <= '0;
            divisor <= cfg.height;
            dvd     <= DVD_W'(SPAN_Y) * DVD_W'(in_y);
            state   <= in_bad ? F_PUSH : F_DIV_RE;
          end
        end
        F_DIV_RE: begin
          rem <= rem_step;
          dvd <= dvd_step;
          cnt <= cnt + DIV_CNT_W'(1);
          if (last) begin
            // real part done, start the column division
            re0     <= $signed(FX_W'(quot)) - OFF_Y;
            rem     <= '0;
            cnt     <= '0;
            divisor <= cfg.width;
            dvd     <= DVD_W'(SPAN_X) * DVD_W'(pix_x);
            state   <= F_DIV_IM;
          end
        end
        F_DIV_IM: begin
          rem <= rem_step;
          dvd <= dvd_step;
          cnt <= cnt + DIV_CNT_W'(1);
          if (last) begin
            im0   <= $signed(FX_W'(quot)) - OFF_X;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jetp_queue.sv -----
// Short queue of start points between the front end and the iteration unit.
// Uses jetp_pkg for the entry type and depth.
`default_nettype none

module jetp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  jetp_pkg::seed_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output jetp_pkg::seed_t pop_data
);
  import jetp_pkg::*;

  seed_t             slots [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jetp_iter.sv -----
// Back end: runs the escape-time loop on one start point, looks up the colour
// and holds the result in the output register. Uses jetp_pkg.
`default_nettype none

module jetp_iter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           seed_valid,
  output logic                           seed_ready,
  input  jetp_pkg::seed_t                seed,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jetp_pkg::M_TDATA_W-1:0] m_tdata,  // red, green, blue, iterations_left
  output logic                           m_tuser   // coord_error
);
  import jetp_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_UPD,
    B_DONE
  } back_state_t;

  back_state_t            state;
  logic signed [FX_W-1:0] re;
  logic signed [FX_W-1:0] im;
  logic [ITER_W-1:0]      n;
  logic                   err;
  logic [PROD_W-1:0]      prod_ii;
  logic [PROD_W-1:0]      prod_rr;
  logic [PROD_W-1:0]      prod_ir;
  logic                   sign_diff;
  color_t                 out_color;
  logic [ITER_OUT_W-1:0]  out_iter;
  logic                   out_err;

  color_t color_rom [0:ITER_LIMIT];

  for (genvar g = 0; g <= ITER_LIMIT; g++) begin : g_rom
    localparam color_t ENTRY = color_entry(g);
    assign color_rom[g] = ENTRY;
  end

  logic [FX_W-1:0]        ai;
  logic [FX_W-1:0]        ar;
  logic [SQ_W-1:0]        si;
  logic [SQ_W-1:0]        sr;
  logic [SUM_W-1:0]       mag_sum;
  logic                   escape;
  logic [FX_W-1:0]        cross_mag;
  logic signed [FX_W-1:0] cross_s;
  logic signed [FX_W-1:0] re_next;
  logic signed [FX_W-1:0] im_next;

  assign ai = im[FX_W-1] ? FX_W'(-im) : FX_W'(im);
  assign ar = re[FX_W-1] ? FX_W'(-re) : FX_W'(re);

  assign si      = prod_ii[PROD_W-1:FRAC];
  assign sr      = prod_rr[PROD_W-1:FRAC];
  assign mag_sum = {1'b0, si} + {1'b0, sr};
  assign escape  = mag_sum >= FOUR;

  // 2*|im|*|re| truncated, then the sign of the product
  assign cross_mag = prod_ir[FX_W+FRAC-2:FRAC-1];
  assign cross_s   = sign_diff ? -$signed(cross_mag) : $signed(cross_mag);
  assign re_next   = cross_s + C_IM;
  assign im_next   = $signed(si[FX_W-1:0]) - $signed(sr[FX_W-1:0]) + C_RE;

  assign seed_ready = state == B_IDLE;
  assign m_tdata    = {(M_TDATA_W - ITER_LSB - ITER_OUT_W)'(0), out_iter, out_color};
  assign m_tuser    = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != B_DONE) m_tvalid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (seed_valid) begin
            re    <= seed.re;
            im    <= seed.im;
            err   <= seed.err;
            n     <= seed.err ? '0 : ITER_W'(ITER_LIMIT);
            state <= seed.err ? B_DONE : B_MUL;
          end
        end
        B_MUL: begin
          prod_ii   <= PROD_W'(ai) * PROD_W'(ai);
          prod_rr   <= PROD_W'(ar) * PROD_W'(ar);
          prod_ir   <= PROD_W'(ai) * PROD_W'(ar);
          sign_diff <= im[FX_W-1] != re[FX_W-1];
          state     <= B_UPD;
        end
        B_UPD: begin
          if (escape) begin
            state <= B_DONE;
          end else begin
            re    <= re_next;
            im    <= im_next;
            n     <= n - ITER_W'(1);
            state <= (n == ITER_W'(1)) ? B_DONE : B_MUL;
          end
        end
        B_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_color <= err ? '0 : color_rom[n];
            out_iter  <= ITER_OUT_W'(n);
            out_err   <= err;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/julia_escape_time_pixel.sv -----
// Julia-set escape-time pixel colour: top level with the configuration registers.
// Depends on jetp_pkg, jetp_front, jetp_queue and jetp_iter.
//
// Usage:
//   s_* carries one pixel request per transfer (column in tdata[11:0], row in
//   tdata[23:12]); m_* returns one colour per request, in request order.
//   cfg_we/cfg_index/cfg_data set image width (index 0) and height (index 1);
//   write them only while no request is in flight.
// Timing:
//   The front end passes an out-of-image request straight to the queue; a
//   valid one takes two 42-step restoring divisions, one quotient bit per
//   cycle. The iteration unit runs each loop pass as a multiply step, then
//   a test and update step; a pixel stops after k passes, and k is at most
//   300. A two-entry queue lets the front end map the next pixel while the
//   current one loops.
// Reset: rst is synchronous; it empties the queue, drops any result in the
//   output register and restores width 1024 and height 512.
// Stall: while m_tready is low the result is held; the iteration unit keeps
//   working on the next pixel and waits only when it has a second result.
`default_nettype none

module julia_escape_time_pixel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [jetp_pkg::S_TDATA_W-1:0] s_tdata,   // pixel_x, pixel_y
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jetp_pkg::M_TDATA_W-1:0] m_tdata,   // red, green, blue, iterations_left
  output logic                           m_tuser,   // coord_error
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [jetp_pkg::DIM_W-1:0]     cfg_data
);
  import jetp_pkg::*;

  cfg_t  cfg;
  logic  push_valid;
  logic  push_ready;
  seed_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  seed_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= WIDTH_RESET;
      cfg.height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg.width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.height <= cfg_data;
      endcase
    end
  end

  jetp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  jetp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  jetp_iter u_iter (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (pop_valid),
    .seed_ready (pop_ready),
    .seed       (pop_data),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/jetp_checker.sv -----
// Port-level checks for julia_escape_time_pixel, attached by bind.
// Depends on jetp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module jetp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [jetp_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser
);
  import jetp_pkg::*;

  `CHK_ASSERT_ALWAYS(a_reset_drops_result, clk, rst |=> !m_tvalid, "result left after reset")

  `CHK_ASSERT(a_valid_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped")

  `CHK_ASSERT(a_data_holds, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  `CHK_ASSERT(a_error_black, clk, rst, m_tvalid && m_tuser |-> m_tdata == '0, "error pixel not black")

  `CHK_ASSERT(a_iter_bound, clk, rst, m_tvalid && !m_tuser |-> m_tdata[ITER_LSB +: ITER_OUT_W] <= ITER_OUT_W'(ITER_OUT_MAX), "budget out of range")

endmodule

bind julia_escape_time_pixel jetp_checker u_checker (.*);

`default_nettype wire
